### rtl/core/tsc_pkg.sv
// Shared types, constants and the CRC-8 step for the scratchpad checker.
`default_nettype none

package tsc_pkg;

  // Default size of the per-sensor table
  localparam int MAX_SENSORS_DEF = 16;

  localparam int IDX_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int RAW_W   = 16;
  localparam int COUNT_W = 5;
  localparam int TEMP_W  = 17;
  localparam int POS_W   = 4;

  localparam logic [BYTE_W-1:0] CRC_POLY     = 8'h8C;
  localparam logic [BYTE_W-1:0] CRC_GOOD     = 8'h00;
  localparam logic [RAW_W-1:0]  POWER_ON_RAW = 16'd1360;
  localparam int                SIGN_BIT     = 12;
  localparam logic [POS_W-1:0]  POS_LAST     = 4'd15;

  // Result codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC      = 2'd1,
    ST_RANGE    = 2'd2,
    ST_POWER_ON = 2'd3
  } status_t;

  // Closed frame handed from the byte stage to the check stage
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [RAW_W-1:0] raw;
    logic             crc_ok;
    logic             range_ok;
  } frame_t;

  // One byte of the Dallas CRC-8, least significant bit first
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/temp_scratchpad_checker.sv
// Top level of the scratchpad checker: byte stage, table check stage, result register.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid in_ready in_sensor_index in_pad_byte  | sink
//          | in_pad_last                                    |
//  out     | out_valid out_ready out_temperature out_status | source
//  cfg     | cfg_wr_en cfg_wr_data (sensor_count)           | sink
//
// One beat per cycle is taken while in_ready is high; a result passes the check stage
// register and the result register. The table is read at the last beat, written when
// the stage moves on; a write is forwarded to a read of the same sensor in the same cycle.
// Synchronous reset empties the table at once through valid bits, no clearing pass.
// A stalled result holds the check stage; in_ready then drops until it moves on.
`default_nettype none

module temp_scratchpad_checker #(
  parameter int MAX_SENSORS = tsc_pkg::MAX_SENSORS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tsc_pkg::IDX_W-1:0]     in_sensor_index,
  input  wire logic [tsc_pkg::BYTE_W-1:0]    in_pad_byte,
  input  wire logic                          in_pad_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [tsc_pkg::TEMP_W-1:0]  out_temperature,
  output logic [1:0]                         out_status,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tsc_pkg::COUNT_W-1:0]   cfg_wr_data
);

  localparam int ADDR_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

  logic [tsc_pkg::COUNT_W-1:0]       count_r;
  tsc_pkg::frame_t                   frame;
  logic                              frame_fire;
  logic                              beat_accept;
  logic                              s1_valid_r, s1_valid_nxt;
  tsc_pkg::frame_t                   s1_frame_r;
  logic                              s1_go;
  logic [tsc_pkg::RAW_W-1:0]         stored;
  tsc_pkg::status_t                  s1_status;
  logic signed [tsc_pkg::TEMP_W-1:0] s1_temp;
  logic                              s1_write;
  logic [31:0]                       rd_idx_ext, wr_idx_ext;
  logic                              out_valid_r, out_valid_nxt;
  tsc_pkg::status_t                  out_status_r;
  logic signed [tsc_pkg::TEMP_W-1:0] out_temp_r;

  // Sensor count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // Handshake: the check stage must be free or moving on
  assign s1_go       = !out_valid_r || out_ready;
  assign in_ready    = !s1_valid_r || s1_go;
  assign beat_accept = in_valid && in_ready;

  tsc_frame #(
    .MAX_SENSORS (MAX_SENSORS)
  ) u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_accept  (beat_accept),
    .sensor_index (in_sensor_index),
    .pad_byte     (in_pad_byte),
    .pad_last     (in_pad_last),
    .sensor_count (count_r),
    .frame        (frame),
    .frame_fire   (frame_fire)
  );

  assign rd_idx_ext = 32'(frame.idx);
  assign wr_idx_ext = 32'(s1_frame_r.idx);

  tsc_table #(
    .DEPTH  (MAX_SENSORS),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (frame_fire),
    .rd_addr (rd_idx_ext[ADDR_W-1:0]),
    .wr_en   (s1_write),
    .wr_addr (wr_idx_ext[ADDR_W-1:0]),
    .wr_data (s1_frame_r.raw),
    .rd_data (stored)
  );

  // Check stage: decide the outcome against the stored value
  always_comb begin
    s1_temp = '0;
    if (!s1_frame_r.range_ok) begin
      s1_status = tsc_pkg::ST_RANGE;
    end else if (!s1_frame_r.crc_ok) begin
      s1_status = tsc_pkg::ST_CRC;
    end else if ((s1_frame_r.raw == tsc_pkg::POWER_ON_RAW) && (stored == '0)) begin
      s1_status = tsc_pkg::ST_POWER_ON;
    end else begin
      s1_status = tsc_pkg::ST_OK;
      s1_temp   = {s1_frame_r.raw[tsc_pkg::SIGN_BIT], s1_frame_r.raw};
    end
  end

  assign s1_write = s1_valid_r && s1_go && (s1_status == tsc_pkg::ST_OK);

  // Advance the check stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (frame_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_fire) begin
      s1_frame_r <= frame;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_valid_r && s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_go) begin
      out_status_r <= s1_status;
      out_temp_r   <= s1_temp;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_temperature = out_temp_r;
  assign out_status      = out_status_r;

endmodule

`default_nettype wire

### rtl/core/tsc_frame.sv
// Byte stage: running CRC, byte count, raw capture and frame close.
`default_nettype none

module tsc_frame #(
  parameter int MAX_SENSORS = tsc_pkg::MAX_SENSORS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         beat_accept,
  input  wire logic [tsc_pkg::IDX_W-1:0]    sensor_index,
  input  wire logic [tsc_pkg::BYTE_W-1:0]   pad_byte,
  input  wire logic                         pad_last,
  input  wire logic [tsc_pkg::COUNT_W-1:0]  sensor_count,
  output tsc_pkg::frame_t                   frame,
  output logic                              frame_fire
);

  logic [tsc_pkg::BYTE_W-1:0] crc_r, crc_nxt;
  logic [tsc_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [tsc_pkg::BYTE_W-1:0] lo_r, lo_nxt;
  logic [tsc_pkg::BYTE_W-1:0] hi_r, hi_nxt;
  logic [tsc_pkg::BYTE_W-1:0] crc_upd;
  logic [tsc_pkg::BYTE_W-1:0] lo_upd, hi_upd;
  logic [31:0]                idx_ext;

  // Fold the current beat into the frame
  always_comb begin
    crc_upd = tsc_pkg::crc8_update(crc_r, pad_byte);
    lo_upd  = (pos_r == '0) ? pad_byte : lo_r;
    hi_upd  = (pos_r == tsc_pkg::POS_W'(1)) ? pad_byte : hi_r;
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    if (beat_accept) begin
      if (pad_last) begin
        crc_nxt = '0;
        pos_nxt = '0;
        lo_nxt  = '0;
        hi_nxt  = '0;
      end else begin
        crc_nxt = crc_upd;
        pos_nxt = (pos_r == tsc_pkg::POS_LAST) ? pos_r : pos_r + tsc_pkg::POS_W'(1);
        lo_nxt  = lo_upd;
        hi_nxt  = hi_upd;
      end
    end
  end

  // Hold the frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      pos_r <= '0;
      lo_r  <= '0;
      hi_r  <= '0;
    end else begin
      crc_r <= crc_nxt;
      pos_r <= pos_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
    end
  end

  // Close the frame on the last beat
  assign idx_ext        = 32'(sensor_index);
  assign frame.idx      = sensor_index;
  assign frame.raw      = {hi_upd, lo_upd};
  assign frame.crc_ok   = (crc_upd == tsc_pkg::CRC_GOOD);
  assign frame.range_ok = ({1'b0, sensor_index} < sensor_count) &&
                          (idx_ext < 32'(MAX_SENSORS));
  assign frame_fire     = beat_accept && pad_last;

endmodule

`default_nettype wire

### rtl/core/tsc_table.sv
// Per-sensor last-value memory with valid bits and write-to-read forwarding.
`default_nettype none

module tsc_table #(
  parameter int DEPTH  = tsc_pkg::MAX_SENSORS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       rd_en,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  input  wire logic                       wr_en,
  input  wire logic [ADDR_W-1:0]          wr_addr,
  input  wire logic [tsc_pkg::RAW_W-1:0]  wr_data,
  output logic [tsc_pkg::RAW_W-1:0]       rd_data
);

  logic [tsc_pkg::RAW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          valid_r;
  logic [tsc_pkg::RAW_W-1:0] q_r;
  logic                      q_valid_r;
  logic                      fwd_r;
  logic [tsc_pkg::RAW_W-1:0] fwd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // Valid bits and forwarding flag; reset empties the table at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      if (rd_en) begin
        q_valid_r <= valid_r[rd_addr];
        fwd_r     <= wr_en && (wr_addr == rd_addr);
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Pick forwarded data, then memory, else the cleared value
  assign rd_data = fwd_r     ? fwd_data_r :
                   q_valid_r ? q_r        : '0;

endmodule

`default_nettype wire
